[rtl/rsc_pkg.sv]
// ----------------------------------------------------------------------------
// rsc_pkg: shared types and constants of the regex syntax checker
// Byte codes, error and warning codes, payload structs and small helpers.
// ----------------------------------------------------------------------------
package rsc_pkg;

    // Default configuration
    localparam int DEF_MAX_GROUP_DEPTH = 255;
    localparam int DEF_COLUMN_BITS     = 16;
    localparam int COL_W               = 16;

    // Byte codes of interest
    localparam logic [7:0] CH_OR     = 8'h7C; // '|'
    localparam logic [7:0] CH_LBRACK = 8'h5B; // '['
    localparam logic [7:0] CH_RBRACK = 8'h5D; // ']'
    localparam logic [7:0] CH_LPAREN = 8'h28; // '('
    localparam logic [7:0] CH_RPAREN = 8'h29; // ')'
    localparam logic [7:0] CH_DASH   = 8'h2D; // '-'
    localparam logic [7:0] CH_STAR   = 8'h2A; // '*'
    localparam logic [7:0] CH_QMARK  = 8'h3F; // '?'
    localparam logic [7:0] CH_PLUS   = 8'h2B; // '+'
    localparam logic [7:0] CH_BSLASH = 8'h5C; // backslash
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Error codes
    localparam logic [3:0] ERR_NONE          = 4'd0;
    localparam logic [3:0] ERR_EMPTY_OR      = 4'd1;
    localparam logic [3:0] ERR_NESTED_BRACK  = 4'd2;
    localparam logic [3:0] ERR_EMPTY_BRACK   = 4'd3;
    localparam logic [3:0] ERR_NO_LBRACK     = 4'd4;
    localparam logic [3:0] ERR_EMPTY_GROUP   = 4'd5;
    localparam logic [3:0] ERR_NO_LPAREN     = 4'd6;
    localparam logic [3:0] ERR_LEAD_QUAL     = 4'd7;
    localparam logic [3:0] ERR_DOUBLE_QUAL   = 4'd8;
    localparam logic [3:0] ERR_QUAL_AFTER_OR = 4'd9;
    localparam logic [3:0] ERR_NO_RPAREN     = 4'd10;
    localparam logic [3:0] ERR_NO_RBRACK     = 4'd11;
    localparam logic [3:0] ERR_TOO_DEEP      = 4'd12;

    // Warning codes
    localparam logic [1:0] WARN_NONE       = 2'd0;
    localparam logic [1:0] WARN_OR_AFTER_Q = 2'd1;
    localparam logic [1:0] WARN_INV_RANGE  = 2'd2;
    localparam logic [1:0] WARN_ONE_RANGE  = 2'd3;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_last;
    } rsc_in_t;

    typedef struct packed {
        logic [3:0]       error_code;
        logic [1:0]       warning_code;
        logic [COL_W-1:0] column;
        logic             done_res;
        logic             expression_ok;
    } rsc_out_t;

    // Single-bit parser flags
    typedef struct packed {
        logic at_start;
        logic bracket_open;
        logic failed;
        logic range_pending;
    } rsc_flags_t;

    localparam rsc_flags_t FLAGS_RESET = '{at_start: 1'b1, bracket_open: 1'b0,
                                           failed: 1'b0, range_pending: 1'b0};

    function automatic logic [1:0] range_warn(input logic [7:0] lo, input logic [7:0] hi);
        logic [1:0] w;
        w = WARN_NONE;
        if (lo > hi) begin
            w = WARN_INV_RANGE;
        end else if (lo == hi) begin
            w = WARN_ONE_RANGE;
        end
        return w;
    endfunction

    function automatic logic is_qual(input logic [7:0] c);
        return (c == CH_STAR) || (c == CH_QMARK) || (c == CH_PLUS);
    endfunction

endpackage

[rtl/rsc_step.sv]
// ----------------------------------------------------------------------------
// rsc_step: per-byte syntax evaluation
// Combinational next-state and result for one byte against the parser state.
// ----------------------------------------------------------------------------
module rsc_step #(
    parameter int MAX_GROUP_DEPTH = rsc_pkg::DEF_MAX_GROUP_DEPTH,
    parameter int COLUMN_BITS     = rsc_pkg::DEF_COLUMN_BITS,
    parameter int DEPTH_W         = $clog2(MAX_GROUP_DEPTH + 1)
) (
    input  rsc_pkg::rsc_in_t    in_data,
    input  logic [7:0]          prev_char,
    input  rsc_pkg::rsc_flags_t flags,
    input  logic [DEPTH_W-1:0]  depth,
    input  logic [7:0]          range_start,
    input  logic [COLUMN_BITS-1:0] pos,
    output logic [7:0]          prev_char_next,
    output rsc_pkg::rsc_flags_t flags_next,
    output logic [DEPTH_W-1:0]  depth_next,
    output logic [7:0]          range_start_next,
    output logic [COLUMN_BITS-1:0] pos_next,
    output rsc_pkg::rsc_out_t   out_data
);
    import rsc_pkg::*;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_GROUP_DEPTH);

    logic [7:0]          cur;
    logic                last;
    logic                esc;
    logic [3:0]          err;
    logic [1:0]          warn;
    rsc_flags_t          fl;
    logic [DEPTH_W-1:0]  dep;
    logic [7:0]          rstart;
    logic [COL_W-1:0]    col_sat;

    assign cur  = in_data.char_in;
    assign last = in_data.is_last;
    assign esc  = (prev_char == CH_BSLASH);

    always_comb begin
        err    = ERR_NONE;
        warn   = WARN_NONE;
        fl     = flags;
        dep    = depth;
        rstart = range_start;

        if (!flags.failed) begin
            if (flags.range_pending) begin
                warn = range_warn(range_start, cur);
            end
            fl.range_pending = 1'b0;

            // alternation
            if (cur == CH_OR) begin
                if (flags.at_start || prev_char == CH_OR || prev_char == CH_LPAREN ||
                    prev_char == CH_RPAREN || last) begin
                    err = ERR_EMPTY_OR;
                end else if ((prev_char == CH_STAR || prev_char == CH_QMARK) &&
                             warn == WARN_NONE) begin
                    warn = WARN_OR_AFTER_Q;
                end
            end

            // brackets
            if (err == ERR_NONE && !esc) begin
                if (cur == CH_LBRACK) begin
                    if (fl.bracket_open) err = ERR_NESTED_BRACK;
                    else fl.bracket_open = 1'b1;
                end else if (cur == CH_RBRACK) begin
                    if (prev_char == CH_LBRACK) err = ERR_EMPTY_BRACK;
                    else if (!fl.bracket_open) err = ERR_NO_LBRACK;
                    else fl.bracket_open = 1'b0;
                end
            end

            // groups
            if (err == ERR_NONE && !esc) begin
                if (cur == CH_LPAREN) begin
                    if (dep >= DEPTH_MAX) err = ERR_TOO_DEEP;
                    else dep = dep + DEPTH_W'(1);
                end else if (cur == CH_RPAREN) begin
                    if (prev_char == CH_LPAREN) err = ERR_EMPTY_GROUP;
                    else if (dep == '0) err = ERR_NO_LPAREN;
                    else dep = dep - DEPTH_W'(1);
                end
            end

            // qualifiers
            if (err == ERR_NONE && !esc && is_qual(cur)) begin
                if (flags.at_start) err = ERR_LEAD_QUAL;
                else if (is_qual(prev_char)) err = ERR_DOUBLE_QUAL;
                else if (prev_char == CH_OR) err = ERR_QUAL_AFTER_OR;
            end

            // range inside brackets: check now at end of string, else defer
            if (err == ERR_NONE && fl.bracket_open && cur == CH_DASH) begin
                if (last) begin
                    if (warn == WARN_NONE) warn = range_warn(prev_char, CH_NUL);
                end else begin
                    fl.range_pending = 1'b1;
                    rstart           = prev_char;
                end
            end

            // end of string balance
            if (err == ERR_NONE && last) begin
                if (dep != '0) err = ERR_NO_RPAREN;
                else if (fl.bracket_open) err = ERR_NO_RBRACK;
            end

            if (err != ERR_NONE) fl.failed = 1'b1;
        end
    end

    always_comb begin
        out_data.error_code    = err;
        out_data.warning_code  = warn;
        out_data.column        = col_sat;
        out_data.done_res      = last;
        out_data.expression_ok = last && !fl.failed;

        if (last) begin
            prev_char_next   = '0;
            flags_next       = FLAGS_RESET;
            depth_next       = '0;
            range_start_next = '0;
            pos_next         = '0;
        end else begin
            prev_char_next   = cur;
            flags_next       = fl;
            flags_next.at_start = 1'b0;
            depth_next       = dep;
            range_start_next = rstart;
            pos_next         = (pos == '1) ? pos : pos + COLUMN_BITS'(1);
        end
    end

    // column saturates at the field's top value
    generate
        if (COLUMN_BITS <= COL_W) begin : g_col_narrow
            assign col_sat = COL_W'(pos);
        end else begin : g_col_wide
            assign col_sat = (|pos[COLUMN_BITS-1:COL_W]) ? '1 : pos[COL_W-1:0];
        end
    endgenerate

endmodule

[rtl/regex_syntax_checker_unit.sv]
// ----------------------------------------------------------------------------
// regex_syntax_checker_unit: streaming regular-expression syntax checker
// Checks an expression one byte per transfer, one result transfer per byte.
// ----------------------------------------------------------------------------
//
//  channel | ports                      | payload         | direction
//  --------+----------------------------+-----------------+----------
//  input   | s_valid, s_ready, s_data   | rsc_in_t        | in
//  result  | m_valid, m_ready, m_data   | rsc_out_t       | out
//
//  Throughput is one byte per clock while m_ready holds high: the parser
//  step is combinational, from the input register straight into the result
//  register. An accepted byte moves from the input register into the result
//  register; m_valid then rises and its result can be transferred.
//  aresetn (synchronous, active low) returns the parser to the start of a
//  new expression and empties both registers.
//  With m_ready low the result register holds, the input register takes one
//  more byte, then s_ready drops until the result is taken.
//
module regex_syntax_checker_unit #(
    parameter int MAX_GROUP_DEPTH = rsc_pkg::DEF_MAX_GROUP_DEPTH,
    parameter int COLUMN_BITS     = rsc_pkg::DEF_COLUMN_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rsc_pkg::rsc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rsc_pkg::rsc_out_t m_data
);
    import rsc_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_GROUP_DEPTH + 1);

    // Input register
    logic    in_valid_reg;
    rsc_in_t in_data_reg;

    // Result register
    logic     out_valid_reg;
    rsc_out_t out_data_reg;

    // Parser state
    logic [7:0]             prev_char_reg,   prev_char_next;
    rsc_flags_t             flags_reg,       flags_next;
    logic [DEPTH_W-1:0]     depth_reg,       depth_next;
    logic [7:0]             range_start_reg, range_start_next;
    logic [COLUMN_BITS-1:0] pos_reg,         pos_next;
    rsc_out_t               result_next;

    // The result register can take a new value when it is empty or being read.
    logic advance;
    logic step_en;

    assign advance = !out_valid_reg || m_ready;
    assign step_en = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    rsc_step #(
        .MAX_GROUP_DEPTH (MAX_GROUP_DEPTH),
        .COLUMN_BITS     (COLUMN_BITS),
        .DEPTH_W         (DEPTH_W)
    ) u_step (
        .in_data          (in_data_reg),
        .prev_char        (prev_char_reg),
        .flags            (flags_reg),
        .depth            (depth_reg),
        .range_start      (range_start_reg),
        .pos              (pos_reg),
        .prev_char_next   (prev_char_next),
        .flags_next       (flags_next),
        .depth_next       (depth_next),
        .range_start_next (range_start_next),
        .pos_next         (pos_next),
        .out_data         (result_next)
    );

    // Input stage: refills whenever it is empty or its byte moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_data_reg <= result_next;
        end
    end

    // Parser state advances once per byte that reaches the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_char_reg   <= '0;
            flags_reg       <= FLAGS_RESET;
            depth_reg       <= '0;
            range_start_reg <= '0;
            pos_reg         <= '0;
        end else if (step_en) begin
            prev_char_reg   <= prev_char_next;
            flags_reg       <= flags_next;
            depth_reg       <= depth_next;
            range_start_reg <= range_start_next;
            pos_reg         <= pos_next;
        end
    end

`ifndef SYNTHESIS
    a_err_not_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.error_code != ERR_NONE) |-> !m_data.expression_ok)
        else $error("expression_ok set alongside an error");

    a_ok_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.expression_ok |-> m_data.done_res)
        else $error("expression_ok set on a byte that is not last");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(MAX_GROUP_DEPTH))
        else $error("group depth beyond its limit");

    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && in_data_reg.is_last |=>
            (pos_reg == '0) && flags_reg.at_start && !flags_reg.failed &&
            (depth_reg == '0) && !flags_reg.bracket_open)
        else $error("parser not re-armed after last byte");

    a_failed_no_range: assert property (@(posedge aclk) disable iff (!aresetn)
        flags_reg.failed |-> !flags_reg.range_pending)
        else $error("range check pending after failure");
`endif

endmodule
